/* src/rmq_pkg.sv */
`default_nettype none

package rmq_pkg;

    // Fixed-point format of the matrix elements and the quaternion.
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int FLD_W     = 16;

    // Largest magnitude of a raw quaternion term is three full-scale
    // elements plus one.
    localparam int MAG_W  = $clog2(3 * 32768 + ONE + 1);
    localparam int Q_W    = MAG_W + 1;

    // The largest normalized magnitude lies in [2^29, 2^30).
    localparam int NRM_W  = 30;
    localparam int SH_W   = $clog2(NRM_W);
    localparam int SQ_W   = 2 * NRM_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // Division: quotient never exceeds ONE.
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int DIVD_W = NRM_W + FRAC_BITS + 1;

    // Queue between the front and back ends.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic signed [Q_W-1:0] S_ONE = Q_W'(ONE);
    localparam logic [FLD_W-1:0] QW_IDENT = (ONE > 32767) ? 16'h7fff : FLD_W'(ONE);

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } rmq_axis_t;

    typedef struct packed {
        logic signed [FLD_W-1:0] m00;
        logic signed [FLD_W-1:0] m01;
        logic signed [FLD_W-1:0] m02;
        logic signed [FLD_W-1:0] m10;
        logic signed [FLD_W-1:0] m11;
        logic signed [FLD_W-1:0] m12;
        logic signed [FLD_W-1:0] m20;
        logic signed [FLD_W-1:0] m21;
        logic signed [FLD_W-1:0] m22;
    } rmq_in_t;

    typedef struct packed {
        logic signed [FLD_W-1:0] qw;
        logic signed [FLD_W-1:0] qx;
        logic signed [FLD_W-1:0] qy;
        logic signed [FLD_W-1:0] qz;
    } rmq_out_t;

    // Classified item: sign and magnitude of the unnormalized quaternion.
    typedef struct packed {
        logic                  ident;
        logic [3:0]            neg;
        logic [3:0][MAG_W-1:0] mag;
    } rmq_item_t;

    // Item after normalization of the magnitudes.
    typedef struct packed {
        logic                  ident;
        logic [3:0]            neg;
        logic [3:0][NRM_W-1:0] mag;
    } rmq_vec_t;

    // Square-root stage contents.
    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        rmq_vec_t          vec;
    } rmq_sq_t;

    // Division stage contents, four lanes.
    typedef struct packed {
        logic                   ident;
        logic [3:0]             neg;
        logic [ROOT_W-1:0]      root;
        logic [3:0][DIVD_W-1:0] rem;
        logic [3:0][QUO_W-1:0]  quo;
    } rmq_div_t;

    // Limit a quotient to ONE, apply the sign and clamp to the field.
    function automatic logic [FLD_W-1:0] rmq_to_field(input logic [QUO_W-1:0] v,
                                                     input logic neg);
        logic [QUO_W-1:0] lim;
        logic [31:0]      ext;
        logic [31:0]      nv;
        lim = (v > QUO_W'(ONE)) ? QUO_W'(ONE) : v;
        ext = 32'(lim);
        nv  = 32'd0 - ext;
        if (!neg) begin
            rmq_to_field = (ext > 32'd32767) ? 16'h7fff : ext[FLD_W-1:0];
        end else begin
            rmq_to_field = (ext > 32'd32768) ? 16'h8000 : nv[FLD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* src/rmq_front.sv */
`default_nettype none

module rmq_front import rmq_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire rmq_in_t   s_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output rmq_item_t      out_item
);

    logic signed [Q_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [Q_W-1:0] t, s, s_raw, dii;
    logic signed [Q_W-1:0] q [4];
    rmq_axis_t             axis;
    rmq_item_t             item;
    logic                  fv_reg;
    rmq_item_t             fi_reg;

    // Sign-extend the elements so that sums and differences cannot wrap.
    assign a00 = Q_W'(s_data.m00);
    assign a01 = Q_W'(s_data.m01);
    assign a02 = Q_W'(s_data.m02);
    assign a10 = Q_W'(s_data.m10);
    assign a11 = Q_W'(s_data.m11);
    assign a12 = Q_W'(s_data.m12);
    assign a20 = Q_W'(s_data.m20);
    assign a21 = Q_W'(s_data.m21);
    assign a22 = Q_W'(s_data.m22);

    // Pick the branch and build the unnormalized quaternion.
    always_comb begin
        t     = a00 + a11 + a22;
        axis  = AXIS_X;
        if (a11 > a00) begin
            axis = AXIS_Y;
        end
        dii   = (axis == AXIS_Y) ? a11 : a00;
        if (a22 > dii) begin
            axis = AXIS_Z;
        end
        s_raw = '0;
        s     = '0;
        q[0]  = '0;
        q[1]  = '0;
        q[2]  = '0;
        q[3]  = '0;
        if (t > 0) begin
            s    = t + S_ONE;
            q[0] = s;
            q[1] = a21 - a12;
            q[2] = a02 - a20;
            q[3] = a10 - a01;
        end else begin
            case (axis)
                AXIS_Y: begin
                    s_raw = a11 - a22 - a00 + S_ONE;
                    s     = (s_raw < 0) ? '0 : s_raw;
                    q[0]  = a02 - a20;
                    q[1]  = a01 + a10;
                    q[2]  = s;
                    q[3]  = a21 + a12;
                end
                AXIS_Z: begin
                    s_raw = a22 - a00 - a11 + S_ONE;
                    s     = (s_raw < 0) ? '0 : s_raw;
                    q[0]  = a10 - a01;
                    q[1]  = a02 + a20;
                    q[2]  = a12 + a21;
                    q[3]  = s;
                end
                default: begin
                    s_raw = a00 - a11 - a22 + S_ONE;
                    s     = (s_raw < 0) ? '0 : s_raw;
                    q[0]  = a21 - a12;
                    q[1]  = s;
                    q[2]  = a10 + a01;
                    q[3]  = a20 + a02;
                end
            endcase
        end
        item.ident = (s == 0);
        for (int n = 0; n < 4; n++) begin
            item.neg[n] = q[n][Q_W-1];
            item.mag[n] = q[n][Q_W-1] ? MAG_W'(-q[n]) : MAG_W'(q[n]);
        end
    end

    // One register stage toward the queue.
    assign s_ready   = !fv_reg || out_ready;
    assign out_valid = fv_reg;
    assign out_item  = fi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (s_ready) begin
            fv_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            fi_reg <= item;
        end
    end

endmodule

`default_nettype wire

/* src/rmq_queue.sv */
`default_nettype none

module rmq_queue import rmq_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire rmq_item_t push_item,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output rmq_item_t      pop_item
);

    rmq_item_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != (QPTR_W+1)'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* src/rmq_isqrt.sv */
`default_nettype none

module rmq_isqrt import rmq_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire logic [SUM_W-1:0] in_rad,
    input  wire rmq_vec_t         in_vec,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output rmq_vec_t              out_vec
);

    logic    vld_reg [ROOT_W+1];
    rmq_sq_t st_reg  [ROOT_W+1];

    // Stage zero takes the radicand.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0].rad  <= in_rad;
            st_reg[0].rem  <= '0;
            st_reg[0].root <= '0;
            st_reg[0].vec  <= in_vec;
        end
    end

    // One root bit per stage, two radicand bits brought down each time.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W+1:0] cat;
        logic [REM_W+1:0] trial;
        logic             take;

        assign cat   = {st_reg[k].rem, st_reg[k].rad[SUM_W-1 -: 2]};
        assign trial = (REM_W+2)'({st_reg[k].root, 2'b01});
        assign take  = (cat >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[k+1].rad  <= {st_reg[k].rad[SUM_W-3:0], 2'b00};
                st_reg[k+1].rem  <= take ? REM_W'(cat - trial) : REM_W'(cat);
                st_reg[k+1].root <= {st_reg[k].root[ROOT_W-2:0], take};
                st_reg[k+1].vec  <= st_reg[k].vec;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = st_reg[ROOT_W].root;
    assign out_vec   = st_reg[ROOT_W].vec;

endmodule

`default_nettype wire

/* src/rmq_back.sv */
`default_nettype none

module rmq_back import rmq_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire rmq_item_t in_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output rmq_out_t       m_data
);

    logic                  adv;
    logic                  v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    rmq_item_t             it0_reg, it1_reg, it2_reg;
    logic [MAG_W-1:0]      mx1_reg;
    logic [SH_W-1:0]       sh2_reg;
    rmq_vec_t              vec3_reg, vec4_reg;
    logic [3:0][SQ_W-1:0]  sq4_reg;
    logic [MAG_W-1:0]      mx;
    logic [SH_W-1:0]       sh;
    rmq_vec_t              vec;
    logic [SUM_W-1:0]      sum;
    logic                  sr_valid;
    logic [ROOT_W-1:0]     sr_root;
    rmq_vec_t              sr_vec;
    logic                  dv_valid_reg [QUO_W+1];
    rmq_div_t              dv_reg       [QUO_W+1];
    logic                  m_valid_reg;
    rmq_out_t              m_data_reg;
    rmq_out_t              res;

    // The whole pipeline moves as one unless the result register is held.
    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Largest magnitude.
    always_comb begin
        mx = it0_reg.mag[0];
        for (int n = 1; n < 4; n++) begin
            if (it0_reg.mag[n] > mx) begin
                mx = it0_reg.mag[n];
            end
        end
    end

    // Left shift that brings the largest magnitude to the top bit.
    always_comb begin
        sh = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mx1_reg[b]) begin
                sh = SH_W'(NRM_W - 1 - b);
            end
        end
    end

    always_comb begin
        vec.ident = it2_reg.ident;
        vec.neg   = it2_reg.neg;
        for (int n = 0; n < 4; n++) begin
            vec.mag[n] = NRM_W'(it2_reg.mag[n]) << sh2_reg;
        end
    end

    assign sum = SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) +
                 SUM_W'(sq4_reg[2]) + SUM_W'(sq4_reg[3]);

    // Max, shift, square stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            it0_reg  <= in_item;
            it1_reg  <= it0_reg;
            mx1_reg  <= mx;
            it2_reg  <= it1_reg;
            sh2_reg  <= sh;
            vec3_reg <= vec;
            vec4_reg <= vec3_reg;
            for (int n = 0; n < 4; n++) begin
                sq4_reg[n] <= SQ_W'(vec3_reg.mag[n]) * SQ_W'(vec3_reg.mag[n]);
            end
        end
    end

    rmq_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v4_reg),
        .in_rad    (sum),
        .in_vec    (vec4_reg),
        .out_valid (sr_valid),
        .out_root  (sr_root),
        .out_vec   (sr_vec)
    );

    // Division setup: dividend is mag * ONE plus half the norm.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= sr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0].ident <= sr_vec.ident;
            dv_reg[0].neg   <= sr_vec.neg;
            dv_reg[0].root  <= sr_root;
            dv_reg[0].quo   <= '0;
            for (int n = 0; n < 4; n++) begin
                dv_reg[0].rem[n] <= (DIVD_W'(sr_vec.mag[n]) << FRAC_BITS) +
                                    DIVD_W'(sr_root >> 1);
            end
        end
    end

    // Restoring division, one quotient bit per stage in each lane.
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int B = QUO_W - 1 - k;
        logic [DIVD_W:0] dsh;
        logic [3:0]      take;

        assign dsh = (DIVD_W+1)'(dv_reg[k].root) << B;

        always_comb begin
            for (int n = 0; n < 4; n++) begin
                take[n] = ((DIVD_W+1)'(dv_reg[k].rem[n]) >= dsh);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[k+1].ident <= dv_reg[k].ident;
                dv_reg[k+1].neg   <= dv_reg[k].neg;
                dv_reg[k+1].root  <= dv_reg[k].root;
                for (int n = 0; n < 4; n++) begin
                    dv_reg[k+1].rem[n] <= take[n] ?
                        DIVD_W'((DIVD_W+1)'(dv_reg[k].rem[n]) - dsh) : dv_reg[k].rem[n];
                    dv_reg[k+1].quo[n] <= dv_reg[k].quo[n] | (QUO_W'(take[n]) << B);
                end
            end
        end
    end

    // Saturate, apply signs, or give the identity when the leading term was zero.
    always_comb begin
        if (dv_reg[QUO_W].ident) begin
            res.qw = QW_IDENT;
            res.qx = '0;
            res.qy = '0;
            res.qz = '0;
        end else begin
            res.qw = rmq_to_field(dv_reg[QUO_W].quo[0], dv_reg[QUO_W].neg[0]);
            res.qx = rmq_to_field(dv_reg[QUO_W].quo[1], dv_reg[QUO_W].neg[1]);
            res.qy = rmq_to_field(dv_reg[QUO_W].quo[2], dv_reg[QUO_W].neg[2]);
            res.qz = rmq_to_field(dv_reg[QUO_W].quo[3], dv_reg[QUO_W].neg[3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* src/rotation_matrix_to_quaternion.sv */
`default_nettype none

// Converts a 3x3 rotation matrix (Q1.14) into a normalized, saturated unit
// quaternion (w, x, y, z) in the same format, picking the leading term by the
// trace or the largest diagonal element. A new matrix is taken every clock
// cycle and results leave at one per cycle while the output is not held;
// the delay from input to output comes mostly from the 32 register stages
// of the square-root pipeline and the 16 of the divider that follows it. A
// four-entry queue sits between the classifying front end and the arithmetic
// back end, and the output holds in a register until its transfer completes.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire rmq_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output rmq_out_t     m_data
);

    logic      fr_valid, fr_ready;
    rmq_item_t fr_item;
    logic      bk_valid, bk_ready;
    rmq_item_t bk_item;

    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    rmq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_item   (bk_item)
    );

    rmq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (bk_valid),
        .in_ready (bk_ready),
        .in_item  (bk_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
